>>> hw/rtl/shtp_pkg.sv
package shtp_pkg;

    localparam logic [7:0] FLAG_OCTET  = 8'h7E;
    localparam logic [7:0] ESC_OCTET   = 8'h7D;
    localparam logic [7:0] ESC_MASK    = 8'h20;
    localparam logic [7:0] PROTO_SPACE = 8'h00;
    localparam logic [7:0] PROTO_SHTP  = 8'h01;
    localparam logic [7:0] EXEC_RESET_DONE = 8'h01;

    localparam logic [2:0] FK_SPACE    = 3'd0;
    localparam logic [2:0] FK_ACCEPT   = 3'd1;
    localparam logic [2:0] FK_REJECT   = 3'd2;
    localparam logic [2:0] FK_OTHER    = 3'd3;
    localparam logic [2:0] FK_OVERFLOW = 3'd4;

    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_ROT   = 2'd1;
    localparam logic [1:0] RK_GYRO  = 2'd2;
    localparam logic [1:0] RK_SHORT = 2'd3;

    localparam logic [1:0] DEV_WAIT_RESET = 2'd0;
    localparam logic [1:0] DEV_READY      = 2'd1;
    localparam logic [1:0] DEV_CONFIG     = 2'd2;
    localparam logic [1:0] DEV_RUNNING    = 2'd3;

    localparam int NUM_CFG = 7;
    localparam logic [2:0] CFG_ROT_ID   = 3'd0;
    localparam logic [2:0] CFG_GAME_ID  = 3'd1;
    localparam logic [2:0] CFG_GYRO_ID  = 3'd2;
    localparam logic [2:0] CFG_TS_ID    = 3'd3;
    localparam logic [2:0] CFG_EXE_CHAN = 3'd4;
    localparam logic [2:0] CFG_FIRST_CH = 3'd5;
    localparam logic [2:0] CFG_HIGH_CH  = 3'd6;

    localparam logic [7:0] CFG_RESET [NUM_CFG] = '{8'd5, 8'd8, 8'd2, 8'd251, 8'd1, 8'd3, 8'd5};

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         frame_kind;
        logic [7:0]         channel_num;
        logic [7:0]         rpt_tag;
        logic [1:0]         report_kind;
        logic [1:0]         accuracy;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic signed [15:0] value_d;
        logic [1:0]         device_state;
        logic [15:0]        xmit_room;
        logic [15:0]        bad_count;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic ovf;
        logic host;
    } t_rx_evt;

endpackage

>>> hw/rtl/shtp_uart_deframer_report_parser.sv
// Data, escape and host-event words: one per cycle, back to back while no result is held up.
// Closing flag of a non-empty frame: input stalls while the four header bytes are read,
// each report id is examined, a gyro or rotation report is collected and the word is posted.
// Overflowing data byte: input stalls while its word is posted. The result word is valid
// in the first cycle the input is free again; a stalled result word also stalls the input.
// Synchronous active-low reset clears control and counters, loads config defaults; store and data not cleared.
module shtp_uart_deframer_report_parser import shtp_pkg::*; #(
    parameter int FRAME_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int LW = $clog2(FRAME_BYTES + 1);

    logic          w_acc;
    logic          w_busy;
    logic          w_done;
    t_rx_evt       w_evt;
    logic [LW-1:0] w_len;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    t_out_word     w_res;
    logic          r_out_valid;
    t_out_word     r_out;

    assign o_in_stall = w_busy || (r_out_valid && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;

    shtp_rx_buf #(.FRAME_BYTES(FRAME_BYTES)) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_in      (i_in_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_evt     (w_evt),
        .o_len     (w_len)
    );

    shtp_parse #(.FRAME_BYTES(FRAME_BYTES)) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (w_evt),
        .i_len      (w_len),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_out <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/shtp_rx_buf.sv
module shtp_rx_buf import shtp_pkg::*; #(
    parameter int FRAME_BYTES = 512,
    localparam int AW = $clog2(FRAME_BYTES),
    localparam int LW = $clog2(FRAME_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  t_in_word      i_in,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output t_rx_evt       o_evt,
    output logic [LW-1:0] o_len
);

    logic [7:0]    r_mem [FRAME_BYTES];
    logic [7:0]    r_rd_data;
    logic [LW-1:0] r_len, n_len;
    logic          r_in_frame, n_in_frame;
    logic          r_esc, n_esc;
    logic          w_wr;
    logic [7:0]    w_byte;

    assign w_byte = r_esc ? (i_in.rx_byte ^ ESC_MASK) : i_in.rx_byte;

    always_comb begin
        o_evt      = '0;
        w_wr       = 1'b0;
        n_len      = r_len;
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        if (i_acc) begin
            if (i_in.mode) begin
                o_evt.host = 1'b1;
            end else if (i_in.rx_byte == FLAG_OCTET) begin
                o_evt.start = r_in_frame && (r_len != '0);
                n_in_frame  = 1'b1;
                n_esc       = 1'b0;
                n_len       = '0;
            end else if (r_in_frame) begin
                if (i_in.rx_byte == ESC_OCTET) begin
                    n_esc = 1'b1;
                end else if (r_len < LW'(FRAME_BYTES)) begin
                    w_wr  = 1'b1;
                    n_esc = 1'b0;
                    n_len = r_len + 1'b1;
                end else begin
                    o_evt.ovf  = 1'b1;
                    n_in_frame = 1'b0;
                    n_esc      = 1'b0;
                    n_len      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_len[AW-1:0]] <= w_byte;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_len     = r_len;

endmodule

>>> hw/rtl/shtp_parse.sv
module shtp_parse import shtp_pkg::*; #(
    parameter int FRAME_BYTES = 512,
    localparam int AW = $clog2(FRAME_BYTES),
    localparam int LW = $clog2(FRAME_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    input  t_rx_evt       i_evt,
    input  logic [LW-1:0] i_len,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    output logic          o_busy,
    output logic          o_done,
    output t_out_word     o_res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P0   = 3'd1;
    localparam logic [2:0] ST_P1   = 3'd2;
    localparam logic [2:0] ST_P2   = 3'd3;
    localparam logic [2:0] ST_P3   = 3'd4;
    localparam logic [2:0] ST_RID  = 3'd5;
    localparam logic [2:0] ST_RV   = 3'd6;

    logic [7:0]    r_cfg [NUM_CFG];
    logic [2:0]    r_state, n_state;
    logic          r_done, n_done;
    logic [1:0]    r_dev, n_dev;
    logic [15:0]   r_space, n_space;
    logic [15:0]   r_bad, n_bad;
    logic [LW-1:0] r_n, n_n;
    logic [7:0]    r_proto, n_proto;
    logic [7:0]    r_b1, n_b1;
    logic [7:0]    r_b2, n_b2;
    logic [7:0]    r_chan, n_chan;
    logic [LW-1:0] r_p, n_p;
    logic [LW-1:0] r_rem, n_rem;
    logic [3:0]    r_k, n_k;
    logic [3:0]    r_last, n_last;
    t_out_word     r_res, n_res;
    logic [LW-1:0] n_addr;
    logic [LW-1:0] w_len;
    logic [15:0]   w_plen;
    logic [LW-1:0] w_pl;
    logic          w_in_range;

    assign w_len      = r_n - 1'b1;
    assign w_plen     = {1'b0, r_b2[6:0], r_b1};
    assign w_pl       = LW'(w_plen - 16'd4);
    assign w_in_range = (r_chan >= r_cfg[CFG_FIRST_CH]) && (r_chan <= r_cfg[CFG_HIGH_CH]);

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_dev   = r_dev;
        n_space = r_space;
        n_bad   = r_bad;
        n_n     = r_n;
        n_proto = r_proto;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_chan  = r_chan;
        n_p     = r_p;
        n_rem   = r_rem;
        n_k     = r_k;
        n_last  = r_last;
        n_res   = r_res;
        n_addr  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_evt.host) begin
                    n_dev = DEV_CONFIG;
                end else if (i_evt.ovf) begin
                    n_res            = '0;
                    n_res.frame_kind = FK_OVERFLOW;
                    n_bad            = r_bad + 16'd1;
                    n_done           = 1'b1;
                end else if (i_evt.start) begin
                    n_res   = '0;
                    n_n     = i_len;
                    n_state = ST_P0;
                end
            end
            ST_P0: begin
                n_proto = i_rd_data;
                n_addr  = LW'(1);
                n_state = ST_P1;
            end
            ST_P1: begin
                n_b1    = i_rd_data;
                n_addr  = LW'(2);
                n_state = ST_P2;
            end
            ST_P2: begin
                n_b2    = i_rd_data;
                n_addr  = LW'(3);
                n_state = ST_P3;
            end
            ST_P3: begin
                n_chan  = i_rd_data;
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_proto == PROTO_SPACE) begin
                    n_res.frame_kind = FK_SPACE;
                    if (r_n >= LW'(3)) n_space = {r_b2, r_b1};
                end else if (r_proto != PROTO_SHTP) begin
                    n_res.frame_kind = FK_OTHER;
                end else begin
                    if (w_len >= LW'(3)) n_res.channel_num = i_rd_data;
                    if ((w_len < LW'(4)) || (w_plen < 16'd4) || (w_plen > 16'(w_len))
                        || (i_rd_data > r_cfg[CFG_HIGH_CH])) begin
                        n_res.frame_kind = FK_REJECT;
                        n_bad            = r_bad + 16'd1;
                    end else begin
                        n_res.frame_kind = FK_ACCEPT;
                        if (r_dev == DEV_WAIT_RESET) n_dev = DEV_READY;
                        if (w_pl != '0) begin
                            n_p     = LW'(5);
                            n_rem   = w_pl;
                            n_addr  = LW'(5);
                            n_done  = 1'b0;
                            n_state = ST_RID;
                        end
                    end
                end
            end
            ST_RID: begin
                n_res.rpt_tag = i_rd_data;
                n_state       = ST_IDLE;
                n_done        = 1'b1;
                if (r_chan == r_cfg[CFG_EXE_CHAN]) begin
                    if (i_rd_data == EXEC_RESET_DONE) n_dev = DEV_READY;
                end else if (!w_in_range) begin
                    n_done = 1'b1;
                end else if (i_rd_data == r_cfg[CFG_TS_ID]) begin
                    if (r_rem < LW'(5)) begin
                        n_res.report_kind = RK_SHORT;
                    end else if (r_rem != LW'(5)) begin
                        // skip timestamp record, fetch next id
                        n_p     = r_p + LW'(5);
                        n_rem   = r_rem - LW'(5);
                        n_addr  = r_p + LW'(5);
                        n_done  = 1'b0;
                        n_state = ST_RID;
                    end
                end else if ((i_rd_data == r_cfg[CFG_ROT_ID])
                             || (i_rd_data == r_cfg[CFG_GAME_ID])) begin
                    if (r_rem < LW'(12)) begin
                        n_res.report_kind = RK_SHORT;
                    end else begin
                        n_res.report_kind = RK_ROT;
                        n_last  = 4'd8;
                        n_k     = 4'd0;
                        n_addr  = r_p + LW'(2);
                        n_done  = 1'b0;
                        n_state = ST_RV;
                    end
                end else if (i_rd_data == r_cfg[CFG_GYRO_ID]) begin
                    if (r_rem < LW'(10)) begin
                        n_res.report_kind = RK_SHORT;
                    end else begin
                        n_res.report_kind = RK_GYRO;
                        n_last  = 4'd6;
                        n_k     = 4'd0;
                        n_addr  = r_p + LW'(2);
                        n_done  = 1'b0;
                        n_state = ST_RV;
                    end
                end else begin
                    n_res.report_kind = RK_SHORT;
                end
            end
            ST_RV: begin
                // k=0: status byte, k=1..8: value bytes at offsets k+3
                case (r_k)
                    4'd0:    n_res.accuracy       = i_rd_data[1:0];
                    4'd1:    n_res.value_a[7:0]   = i_rd_data;
                    4'd2:    n_res.value_a[15:8]  = i_rd_data;
                    4'd3:    n_res.value_b[7:0]   = i_rd_data;
                    4'd4:    n_res.value_b[15:8]  = i_rd_data;
                    4'd5:    n_res.value_c[7:0]   = i_rd_data;
                    4'd6:    n_res.value_c[15:8]  = i_rd_data;
                    4'd7:    n_res.value_d[7:0]   = i_rd_data;
                    4'd8:    n_res.value_d[15:8]  = i_rd_data;
                    default: n_res.accuracy       = r_res.accuracy;
                endcase
                if (r_k == r_last) begin
                    if (r_dev == DEV_CONFIG) n_dev = DEV_RUNNING;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_k    = r_k + 4'd1;
                    n_addr = r_p + LW'(r_k) + LW'(4);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_dev   <= DEV_WAIT_RESET;
            r_space <= '0;
            r_bad   <= '0;
            for (int i = 0; i < NUM_CFG; i++) r_cfg[i] <= CFG_RESET[i];
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_dev   <= n_dev;
            r_space <= n_space;
            r_bad   <= n_bad;
            if (i_cfg_we && (i_cfg_idx < 3'(NUM_CFG))) r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_proto <= n_proto;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_chan  <= n_chan;
        r_p     <= n_p;
        r_rem   <= n_rem;
        r_k     <= n_k;
        r_last  <= n_last;
        r_res   <= n_res;
    end

    assign o_rd_addr = n_addr[AW-1:0];
    assign o_busy    = (r_state != ST_IDLE) || r_done;
    assign o_done    = r_done;

    always_comb begin
        o_res              = r_res;
        o_res.device_state = r_dev;
        o_res.xmit_room    = r_space;
        o_res.bad_count    = r_bad;
    end

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !(i_evt.start || i_evt.ovf || i_evt.host))
        else $error("frame event while parse in progress");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE))
        else $error("result word raised outside idle");
    a_host_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.host |=> (r_dev == DEV_CONFIG))
        else $error("host event did not enter configuring");
`endif

endmodule
